FILE: hdl/pvrt_pkg.sv
//------------------------------------------------------------------------------
// Path-vector route table package
// Shared constants and the route entry type.
//------------------------------------------------------------------------------
`default_nettype none
package pvrt_pkg;
   localparam int ROUTER_MAX_DEF = 32;
   localparam int PATH_MAX_DEF   = 8;
   localparam int STORE_DEPTH    = 32;
   localparam int ID_W           = 5;
   localparam int COST_W         = 16;
   localparam int LEN_W          = 4;
   localparam int PATH_W         = 40;
   localparam int CNT_W          = 6;
   localparam int ENTRY_W        = ID_W + ID_W + COST_W + LEN_W + PATH_W;

   localparam logic [2:0] CMD_CLEAR = 3'd0;
   localparam logic [2:0] CMD_ADD   = 3'd1;
   localparam logic [2:0] CMD_ADV   = 3'd2;
   localparam logic [2:0] CMD_DEAD  = 3'd3;
   localparam logic [2:0] CMD_READ  = 3'd4;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_IGNORE = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;

   localparam logic CSR_MY_ID    = 1'b0;
   localparam logic CSR_INF_COST = 1'b1;

   typedef struct packed {
      logic [ID_W-1:0]   dest;
      logic [ID_W-1:0]   hop;
      logic [COST_W-1:0] cost;
      logic [LEN_W-1:0]  len;
      logic [PATH_W-1:0] path;
   } entry_type;
endpackage
`default_nettype wire

FILE: hdl/pvrt_ram.sv
//------------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
//------------------------------------------------------------------------------
`default_nettype none
module pvrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: hdl/path_vector_route_table_top.sv
// Clear, add and unused commands are decided at accept and go straight to the result state.
// Read passes through a read state; advertise scans the table one slot per cycle through the route
// memory read port, then decides in a separate state; neighbor-dead scans the table the same way.
// One item is in work at a time; the result register frees the next accept.
// Reset clears the route count, my_id to 0 and inf_cost to 999; memory
// contents are undefined until written.
//------------------------------------------------------------------------------
// Path-vector route table top level
// Sequencer around one route memory that scans, updates and reads routes.
//------------------------------------------------------------------------------
`default_nettype none
module path_vector_route_table_top #(
   parameter int ROUTER_MAX = pvrt_pkg::ROUTER_MAX_DEF,
   parameter int PATH_MAX   = pvrt_pkg::PATH_MAX_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic         csr_index,
   input  wire logic [15:0]  csr_data,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [2:0]   req_cmd,
   input  wire logic [4:0]   req_node_id,
   input  wire logic [4:0]   req_sender_id,
   input  wire logic [4:0]   req_packet_dest,
   input  wire logic [4:0]   req_adv_next_hop,
   input  wire logic [15:0]  req_cost,
   input  wire logic [15:0]  req_cost_to_sender,
   input  wire logic [3:0]   req_path_len,
   input  wire logic [39:0]  req_path_ids,
   input  wire logic [4:0]   req_read_index,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic              rsp_changed,
   output logic [1:0]        rsp_status,
   output logic              rsp_entry_valid,
   output logic [4:0]        rsp_entry_dest,
   output logic [4:0]        rsp_entry_next_hop,
   output logic [15:0]       rsp_entry_cost,
   output logic [3:0]        rsp_entry_path_len,
   output logic [39:0]       rsp_entry_path,
   output logic [5:0]        rsp_route_count
);
   import pvrt_pkg::*;

   localparam int TABLE_CAP = (ROUTER_MAX < STORE_DEPTH) ? ROUTER_MAX : STORE_DEPTH;
   localparam int PATH_CAP  = (PATH_MAX < 8) ? PATH_MAX : 8;
   localparam int AW        = $clog2(STORE_DEPTH);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_CHK  = 3'd2;
   localparam logic [2:0] S_DEC  = 3'd3;
   localparam logic [2:0] S_RD   = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [4:0]        my_id_ff;
   logic [15:0]       inf_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   // Latched request.
   logic [2:0]        cmd_ff;
   logic [4:0]        node_ff, snd_ff, advhop_ff, ridx_ff;
   logic [3:0]        plen_ff;
   logic [39:0]       ids_ff;
   logic [16:0]       csum_ff;
   // Scan state.
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [AW-1:0]     chk_addr_ff;
   logic              chk_live_ff;
   logic              found_ff, found_in;
   logic [AW-1:0]     slot_ff, slot_in;
   logic              chg_ff, chg_in;
   logic [1:0]        stat_ff, stat_in;
   entry_type         rdent_ff, rdent_in;
   logic              rdv_ff, rdv_in;
   // Result register.
   logic              rsp_valid_ff;
   logic              rsp_chg_ff;
   logic [1:0]        rsp_stat_ff;
   logic              rsp_ev_ff;
   entry_type         rsp_ent_ff;
   logic [CNT_W-1:0]  rsp_cnt_ff;

   logic              wr_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   entry_type         wr_data, rd_data;
   logic              accept, self_in_path;
   logic [15:0]       c_sat;
   logic              take;
   logic [39:0]       ids_masked;
   logic [39:0]       len_mask;

   pvrt_ram #(.WIDTH(ENTRY_W), .DEPTH(STORE_DEPTH)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign csr_ready = (state_ff == S_IDLE);
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         my_id_ff <= '0;
         inf_ff   <= 16'd999;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_MY_ID) begin
            my_id_ff <= csr_data[4:0];
         end else begin
            inf_ff <= csr_data;
         end
      end
   end

   // Rule check on the advertised path.
   always_comb begin
      self_in_path = 1'b0;
      for (int j = 0; j < 8; j++) begin
         if ((4'(j) < req_path_len) && (req_path_ids[5*j +: 5] == my_id_ff)) begin
            self_in_path = 1'b1;
         end
      end
   end

   assign c_sat = (csum_ff < {1'b0, inf_ff}) ? csum_ff[15:0] : inf_ff;

   always_comb begin
      len_mask = '0;
      for (int j = 0; j < 8; j++) begin
         if (4'(j) < plen_ff) begin
            len_mask[5*j +: 5] = 5'h1f;
         end
      end
   end
   assign ids_masked = ids_ff & len_mask;

   // Install decision for advertised routes, using the found slot's entry.
   always_comb begin
      if (found_ff) begin
         take = (rdent_ff.hop == snd_ff) ||
                ((c_sat < rdent_ff.cost) && (advhop_ff != my_id_ff));
      end else begin
         take = (c_sat < inf_ff) && (advhop_ff != my_id_ff);
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      found_in = found_ff;
      slot_in  = slot_ff;
      chg_in   = chg_ff;
      stat_in  = stat_ff;
      rdent_in = rdent_ff;
      rdv_in   = rdv_ff;
      wr_en    = 1'b0;
      wr_addr  = '0;
      wr_data  = '0;
      rd_addr  = idx_ff[AW-1:0];
      case (state_ff)
         S_IDLE: begin
            rd_addr = req_read_index;
            if (accept) begin
               idx_in   = '0;
               found_in = 1'b0;
               chg_in   = 1'b0;
               stat_in  = ST_OK;
               rdv_in   = 1'b0;
               rdent_in = '0;
               state_in = S_OUT;
               case (req_cmd)
                  CMD_CLEAR: begin
                     wr_en    = 1'b1;
                     wr_data  = '{dest: my_id_ff, hop: my_id_ff, cost: '0,
                                  len: 4'd1, path: 40'(my_id_ff)};
                     count_in = CNT_W'(1);
                     chg_in   = 1'b1;
                  end
                  CMD_ADD: begin
                     if (req_node_id == my_id_ff) begin
                        stat_in = ST_IGNORE;
                     end else if (count_ff >= CNT_W'(TABLE_CAP)) begin
                        stat_in = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[AW-1:0];
                        wr_data  = '{dest: req_node_id, hop: req_node_id,
                                     cost: (req_cost < inf_ff) ? req_cost : inf_ff,
                                     len: 4'd2,
                                     path: {30'd0, req_node_id, my_id_ff}};
                        count_in = count_ff + CNT_W'(1);
                        chg_in   = 1'b1;
                     end
                  end
                  CMD_ADV: begin
                     if ((req_packet_dest != my_id_ff) || (req_node_id == my_id_ff) ||
                         (req_node_id == req_sender_id) || self_in_path) begin
                        stat_in = ST_IGNORE;
                     end else begin
                        rd_addr  = '0;
                        idx_in   = CNT_W'(1);
                        state_in = S_SCAN;
                     end
                  end
                  CMD_DEAD: begin
                     rd_addr  = '0;
                     idx_in   = CNT_W'(1);
                     state_in = S_SCAN;
                  end
                  CMD_READ: begin
                     state_in = S_RD;
                  end
                  default: begin
                     stat_in = ST_IGNORE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // One slot read per cycle; the previous read is checked here.
            rd_addr = idx_ff[AW-1:0];
            if (chk_live_ff) begin
               if (cmd_ff == CMD_DEAD) begin
                  if ((rd_data.hop == node_ff) && (rd_data.cost != inf_ff)) begin
                     wr_en        = 1'b1;
                     wr_addr      = chk_addr_ff;
                     wr_data      = rd_data;
                     wr_data.cost = inf_ff;
                     chg_in       = 1'b1;
                  end
               end else if (rd_data.dest == node_ff) begin
                  found_in = 1'b1;
                  slot_in  = chk_addr_ff;
                  rdent_in = rd_data;
               end
            end
            if (chk_live_ff && (cmd_ff == CMD_ADV) && (rd_data.dest == node_ff)) begin
               state_in = S_DEC;
            end else if (idx_ff > count_ff || idx_ff > CNT_W'(STORE_DEPTH)) begin
               state_in = (cmd_ff == CMD_ADV) ? S_DEC : S_OUT;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         S_DEC: begin
            state_in = S_OUT;
            if (!take) begin
               stat_in = ST_IGNORE;
            end else if (5'(plen_ff) + 5'd1 > 5'(PATH_CAP)) begin
               stat_in = ST_FULL;
            end else if (!found_ff && (count_ff >= CNT_W'(TABLE_CAP))) begin
               stat_in = ST_FULL;
            end else begin
               wr_en   = 1'b1;
               wr_addr = found_ff ? slot_ff : count_ff[AW-1:0];
               wr_data = '{dest: node_ff, hop: snd_ff, cost: c_sat,
                           len: plen_ff + 4'd1, path: {ids_masked[34:0], my_id_ff}};
               if (!found_ff) begin
                  count_in = count_ff + CNT_W'(1);
               end
               chg_in = 1'b1;
            end
         end
         S_RD: begin
            state_in = S_OUT;
            if (CNT_W'(ridx_ff) < count_ff) begin
               rdv_in   = 1'b1;
               rdent_in = rd_data;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         chk_live_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         chk_live_ff <= (state_in == S_SCAN) &&
                        ((state_ff == S_IDLE) ? (count_ff != '0) :
                         (idx_ff < count_ff && idx_ff < CNT_W'(STORE_DEPTH)));
         if (state_ff == S_OUT && !rsp_valid_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      chk_addr_ff <= rd_addr;
      found_ff    <= found_in;
      slot_ff     <= slot_in;
      chg_ff      <= chg_in;
      stat_ff     <= stat_in;
      rdent_ff    <= rdent_in;
      rdv_ff      <= rdv_in;
      if (accept) begin
         cmd_ff    <= req_cmd;
         node_ff   <= req_node_id;
         snd_ff    <= req_sender_id;
         advhop_ff <= req_adv_next_hop;
         ridx_ff   <= req_read_index;
         plen_ff   <= req_path_len;
         ids_ff    <= req_path_ids;
         csum_ff   <= 17'(req_cost) + 17'(req_cost_to_sender);
      end
      if (state_ff == S_OUT && !rsp_valid_ff) begin
         rsp_chg_ff  <= chg_ff;
         rsp_stat_ff <= stat_ff;
         rsp_ev_ff   <= rdv_ff;
         rsp_ent_ff  <= rdv_ff ? rdent_ff : '0;
         rsp_cnt_ff  <= count_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_changed        = rsp_chg_ff;
   assign rsp_status         = rsp_stat_ff;
   assign rsp_entry_valid    = rsp_ev_ff;
   assign rsp_entry_dest     = rsp_ent_ff.dest;
   assign rsp_entry_next_hop = rsp_ent_ff.hop;
   assign rsp_entry_cost     = rsp_ent_ff.cost;
   assign rsp_entry_path_len = rsp_ent_ff.len;
   assign rsp_entry_path     = rsp_ent_ff.path;
   assign rsp_route_count    = rsp_cnt_ff;
endmodule
`default_nettype wire
